>>> hdl/tlps_pkg.sv
// Shared types and constants of the two-level port group split unit.
// Used by the interfaces, register block, controller, datapath and checker.
// No dependencies.
`default_nettype none

package tlps_pkg;

	localparam int TOTAL_W = 48;
	localparam int EB_W    = 5;
	localparam int CH_W    = 5;
	localparam int SHARE_W = 17;
	localparam int PORT_W  = 8;
	localparam int CNT_W   = 48;
	localparam int SIZE_W  = 52;
	localparam int STAT_W  = 2;
	localparam int PROD_W  = CNT_W + SHARE_W;
	localparam int APB_AW  = 6;
	localparam int APB_DW  = 64;

	typedef enum logic [2:0] {
		REG_TOTAL,
		REG_EB,
		REG_L0,
		REG_L1,
		REG_SHARE
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_ZERO_SUM,
		ST_FEW_CH,
		ST_EMPTY
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SUM,
		S_CHECK,
		S_RATIO,
		S_LEVEL,
		S_DLOAD,
		S_DIV,
		S_DTAKE,
		S_SIZE,
		S_EMIT
	} state_t;

	typedef enum logic [1:0] {
		MUL_RATIO,
		MUL_PART,
		MUL_SIZE
	} mul_sel_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total;
		logic [EB_W-1:0]    eb;
		logic [CH_W-1:0]    l0;
		logic [CH_W-1:0]    l1;
		logic [SHARE_W-1:0] share;
	} cfg_t;

	typedef struct packed {
		logic     load;
		logic     sum_start;
		logic     sum_step;
		logic     rd_sum;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     ratio_take;
		logic     next_chan;
		logic     next_level;
		logic     take_rest;
		logic     div_load;
		logic     div_step;
		logic     div_take;
		logic     emit;
		logic     emit_err;
		status_t  err_code;
	} cmd_t;

	typedef struct packed {
		logic sum_done;
		logic err_few;
		logic err_zero;
		logic err_empty;
		logic level_empty;
		logic chan_last;
		logic plan_last;
		logic div_done;
		logic out_busy;
	} sts_t;

endpackage

`default_nettype wire

>>> hdl/tlps_entry_if.sv
// Request channel carrying one channel entry into the split unit.
// Depends on tlps_pkg for field widths.
`default_nettype none

interface tlps_entry_if import tlps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [PORT_W-1:0] ports_in_group;
	logic              final_channel;

	modport source (output valid, output ports_in_group, output final_channel, input ready);
	modport sink (input valid, input ports_in_group, input final_channel, output ready);
endinterface

`default_nettype wire

>>> hdl/tlps_slice_if.sv
// Request channel carrying one result slice out of the split unit.
// Depends on tlps_pkg for field widths.
`default_nettype none

interface tlps_slice_if import tlps_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CNT_W-1:0]  elem_count;
	logic [SIZE_W-1:0] byte_size;
	logic [SIZE_W-1:0] byte_offset;
	logic [STAT_W-1:0] status;
	logic              last_slice;

	modport source (output valid, output elem_count, output byte_size, output byte_offset,
		output status, output last_slice, input ready);
	modport sink (input valid, input elem_count, input byte_size, input byte_offset,
		input status, input last_slice, output ready);
endinterface

`default_nettype wire

>>> hdl/tlps_regs.sv
// APB configuration registers of the split unit.
// Depends on tlps_pkg for the register map and the cfg_t bundle.
`default_nettype none

module tlps_regs import tlps_pkg::*; #(
	parameter int RATIO_FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign idx    = reg_idx_t'(paddr[APB_AW-1:3]);
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.total <= '0;
			cfg_q.eb    <= EB_W'(1);
			cfg_q.l0    <= CH_W'(1);
			cfg_q.l1    <= '0;
			cfg_q.share <= SHARE_W'(1) << RATIO_FRAC_BITS;
		end else if (wr) begin
			unique case (idx)
				REG_TOTAL: cfg_q.total <= pwdata[TOTAL_W-1:0];
				REG_EB:    cfg_q.eb    <= pwdata[EB_W-1:0];
				REG_L0:    cfg_q.l0    <= pwdata[CH_W-1:0];
				REG_L1:    cfg_q.l1    <= pwdata[CH_W-1:0];
				REG_SHARE: cfg_q.share <= pwdata[SHARE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_TOTAL: prdata = APB_DW'(cfg_q.total);
			REG_EB:    prdata = APB_DW'(cfg_q.eb);
			REG_L0:    prdata = APB_DW'(cfg_q.l0);
			REG_L1:    prdata = APB_DW'(cfg_q.l1);
			REG_SHARE: prdata = APB_DW'(cfg_q.share);
			default:   prdata = '0;
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/tlps_ctrl.sv
// Controller state machine of the split unit: sequences loading, the port
// sum pass, the checks, and the per-channel multiply, divide and emit steps.
// Depends on tlps_pkg for state_t, cmd_t and sts_t.
`default_nettype none

module tlps_ctrl import tlps_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic in_final,
	output logic      in_ready,
	input  sts_t      sts,
	output cmd_t      cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (in_final) begin
						cmd.sum_start = 1'b1;
						state_d       = S_SUM;
					end
				end
			end
			S_SUM: begin
				cmd.rd_sum = 1'b1;
				if (sts.sum_done) begin
					state_d = S_CHECK;
				end else begin
					cmd.sum_step = 1'b1;
				end
			end
			S_CHECK: begin
				if (sts.err_few || sts.err_zero || sts.err_empty) begin
					if (!sts.out_busy) begin
						cmd.emit_err = 1'b1;
						if (sts.err_few) begin
							cmd.err_code = ST_FEW_CH;
						end else if (sts.err_zero) begin
							cmd.err_code = ST_ZERO_SUM;
						end else begin
							cmd.err_code = ST_EMPTY;
						end
						state_d = S_IDLE;
					end
				end else begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = MUL_RATIO;
					state_d     = S_RATIO;
				end
			end
			S_RATIO: begin
				cmd.ratio_take = 1'b1;
				state_d        = S_LEVEL;
			end
			S_LEVEL: begin
				if (sts.level_empty) begin
					cmd.next_level = 1'b1;
				end else if (sts.chan_last) begin
					cmd.take_rest = 1'b1;
					state_d       = S_SIZE;
				end else begin
					cmd.mul_en  = 1'b1;
					cmd.mul_sel = MUL_PART;
					state_d     = S_DLOAD;
				end
			end
			S_DLOAD: begin
				cmd.div_load = 1'b1;
				state_d      = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_done) begin
					state_d = S_DTAKE;
				end
			end
			S_DTAKE: begin
				cmd.div_take = 1'b1;
				state_d      = S_SIZE;
			end
			S_SIZE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = MUL_SIZE;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					if (sts.plan_last) begin
						state_d = S_IDLE;
					end else if (sts.chan_last) begin
						cmd.next_level = 1'b1;
						state_d        = S_LEVEL;
					end else begin
						cmd.next_chan = 1'b1;
						state_d       = S_LEVEL;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

`default_nettype wire

>>> hdl/tlps_dp.sv
// Datapath of the split unit: entry store, port sums, shared multiplier,
// bit-serial divider, running offset and the output register.
// Depends on tlps_pkg for cfg_t, cmd_t, sts_t and field widths.
`default_nettype none

module tlps_dp import tlps_pkg::*; #(
	parameter int MAX_CHANNELS    = 16,
	parameter int RATIO_FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  cfg_t                   cfg,
	input  cmd_t                   cmd,
	output sts_t                   sts,
	input  wire logic [PORT_W-1:0] ports_in_group,
	input  wire logic              out_ready,
	output logic                   out_valid,
	output logic      [CNT_W-1:0]  elem_count,
	output logic      [SIZE_W-1:0] byte_size,
	output logic      [SIZE_W-1:0] byte_offset,
	output logic      [STAT_W-1:0] status,
	output logic                   last_slice
);

	localparam int CW    = $clog2(MAX_CHANNELS + 1);
	localparam int IW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int PSW   = PORT_W + CW;
	localparam int NUM_W = CNT_W + PORT_W;
	localparam int DCW   = $clog2(NUM_W);

	logic [PORT_W-1:0]  store_q [MAX_CHANNELS];
	logic [CW-1:0]      loaded_q, sum_idx_q, chan_q;
	logic [PSW-1:0]     psum0_q, psum1_q;
	logic               lvl_q;
	logic [CNT_W-1:0]   cnt0_q, cnt1_q, assigned_q, c_q;
	logic [SIZE_W-1:0]  offset_q;
	logic [PROD_W-1:0]  prod_q;
	logic [NUM_W-1:0]   num_q;
	logic [PSW-1:0]     rem_q;
	logic [DCW-1:0]     div_cnt_q;

	logic [CW-1:0]      n0, n1, avail, n_lvl, base, chan_idx, rd_idx;
	logic [7:0]         l0_8, l1_8, max_8, avail_8;
	logic [CW:0]        n01;
	logic [PORT_W-1:0]  rd_data;
	logic               full;
	logic [CNT_W-1:0]   cnt_lvl, mul_a, cnt0_calc;
	logic [SHARE_W-1:0] mul_b;
	logic [PROD_W-1:0]  ratio_full;
	logic [PSW-1:0]     psum_lvl;
	logic [PSW:0]       r2, r2_sub;
	logic               ge;

	assign max_8   = 8'(MAX_CHANNELS);
	assign l0_8    = 8'(cfg.l0);
	assign l1_8    = 8'(cfg.l1);
	assign n0      = (l0_8 > max_8) ? max_8[CW-1:0] : l0_8[CW-1:0];
	assign avail   = loaded_q - n0;
	assign avail_8 = 8'(avail);
	assign n1      = (avail_8 > l1_8) ? l1_8[CW-1:0] : avail;
	assign n01     = {1'b0, n0} + {1'b0, n1};
	assign full    = (loaded_q == CW'(MAX_CHANNELS));

	assign n_lvl    = lvl_q ? n1 : n0;
	assign base     = lvl_q ? n0 : '0;
	assign chan_idx = base + chan_q;
	assign cnt_lvl  = lvl_q ? cnt1_q : cnt0_q;
	assign psum_lvl = lvl_q ? psum1_q : psum0_q;
	assign rd_idx   = cmd.rd_sum ? sum_idx_q : chan_idx;
	assign rd_data  = store_q[rd_idx[IW-1:0]];

	always_comb begin
		case (cmd.mul_sel)
			MUL_RATIO: begin
				mul_a = cfg.total;
				mul_b = cfg.share;
			end
			MUL_PART: begin
				mul_a = cnt_lvl;
				mul_b = SHARE_W'(rd_data);
			end
			default: begin
				mul_a = c_q;
				mul_b = SHARE_W'(cfg.eb);
			end
		endcase
	end

	assign ratio_full = prod_q >> RATIO_FRAC_BITS;
	assign cnt0_calc  = (cfg.l1 == '0) ? cfg.total :
		(ratio_full > PROD_W'(cfg.total)) ? cfg.total : ratio_full[CNT_W-1:0];

	assign r2     = {rem_q, num_q[NUM_W-1]};
	assign ge     = (r2 >= {1'b0, psum_lvl});
	assign r2_sub = r2 - {1'b0, psum_lvl};

	assign sts.sum_done    = (sum_idx_q == loaded_q);
	assign sts.err_few     = (loaded_q < n0);
	assign sts.err_zero    = ((n0 > CW'(1)) && (psum0_q == '0)) ||
		((n1 > CW'(1)) && (psum1_q == '0));
	assign sts.err_empty   = (n01 == '0);
	assign sts.level_empty = (n_lvl == '0);
	assign sts.chan_last   = (chan_q == n_lvl - CW'(1));
	assign sts.plan_last   = sts.chan_last && (lvl_q || (n1 == '0));
	assign sts.div_done    = (div_cnt_q == DCW'(NUM_W - 1));
	assign sts.out_busy    = out_valid && !out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			store_q[loaded_q[IW-1:0]] <= ports_in_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q  <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.emit_err || (cmd.emit && sts.plan_last)) begin
				loaded_q <= '0;
			end else if (cmd.load && !full) begin
				loaded_q <= loaded_q + CW'(1);
			end
			if (cmd.emit || cmd.emit_err) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum_start) begin
			sum_idx_q <= '0;
			psum0_q   <= '0;
			psum1_q   <= '0;
		end else if (cmd.sum_step) begin
			sum_idx_q <= sum_idx_q + CW'(1);
			if (sum_idx_q < n0) begin
				psum0_q <= psum0_q + PSW'(rd_data);
			end else if ({1'b0, sum_idx_q} < n01) begin
				psum1_q <= psum1_q + PSW'(rd_data);
			end
		end

		if (cmd.mul_en) begin
			prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		end

		if (cmd.ratio_take) begin
			cnt0_q     <= cnt0_calc;
			cnt1_q     <= cfg.total - cnt0_calc;
			lvl_q      <= 1'b0;
			chan_q     <= '0;
			assigned_q <= '0;
			offset_q   <= '0;
		end else begin
			if (cmd.next_level) begin
				lvl_q      <= 1'b1;
				chan_q     <= '0;
				assigned_q <= '0;
			end else if (cmd.next_chan) begin
				chan_q <= chan_q + CW'(1);
			end
			if (cmd.emit) begin
				offset_q <= offset_q + prod_q[SIZE_W-1:0];
				if (!cmd.next_level) begin
					assigned_q <= assigned_q + c_q;
				end
			end
		end

		if (cmd.take_rest) begin
			c_q <= cnt_lvl - assigned_q;
		end else if (cmd.div_take) begin
			c_q <= num_q[CNT_W-1:0];
		end

		if (cmd.div_load) begin
			num_q     <= prod_q[NUM_W-1:0];
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			num_q     <= {num_q[NUM_W-2:0], ge};
			rem_q     <= ge ? r2_sub[PSW-1:0] : r2[PSW-1:0];
			div_cnt_q <= div_cnt_q + DCW'(1);
		end

		if (cmd.emit) begin
			elem_count  <= c_q;
			byte_size   <= prod_q[SIZE_W-1:0];
			byte_offset <= offset_q;
			status      <= STAT_W'(ST_OK);
			last_slice  <= sts.plan_last;
		end else if (cmd.emit_err) begin
			elem_count  <= '0;
			byte_size   <= '0;
			byte_offset <= '0;
			status      <= STAT_W'(cmd.err_code);
			last_slice  <= 1'b1;
		end
	end

endmodule

`default_nettype wire

>>> hdl/two_level_port_group_split_unit.sv
// Top level of the two-level port group split unit.
// Depends on tlps_pkg, tlps_entry_if, tlps_slice_if, tlps_regs, tlps_ctrl and tlps_dp.
//
// Usage: configure total count, element bytes, channel counts per level and
// the level 0 share over the APB port while the unit is idle. Then send one
// request per channel on entry, carrying its port group size; the request
// with final_channel set starts the split. Each channel in use yields one
// request on slice with its element count, byte size and running byte
// offset; last_slice marks the end of the plan. A failed plan yields a
// single request with a nonzero status.
// Operation: a loading entry is taken whenever the unit is idle. A final entry starts
// the port sum pass over the loaded entries and the checks, then a ratio multiply,
// then for each channel that is not the last of its level a multiply and the
// 56-step bit-serial divide, and for a last channel the remainder of its level.
// No new entry is taken until the plan is complete.
// Reset clears the state machine, the entry count and the output valid flag,
// and loads the register defaults. When slice is stalled, the result waits
// in the output register and the unit holds its next result until it leaves.
`default_nettype none

module two_level_port_group_split_unit import tlps_pkg::*; #(
	parameter int MAX_CHANNELS    = 16,
	parameter int RATIO_FRAC_BITS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	tlps_entry_if.sink             entry,
	tlps_slice_if.source           slice,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [APB_AW-1:0] paddr,
	input  wire logic [APB_DW-1:0] pwdata,
	output logic      [APB_DW-1:0] prdata,
	output logic                   pready
);

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	tlps_regs #(
		.RATIO_FRAC_BITS(RATIO_FRAC_BITS)
	) u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	tlps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (entry.valid),
		.in_final (entry.final_channel),
		.in_ready (entry.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tlps_dp #(
		.MAX_CHANNELS    (MAX_CHANNELS),
		.RATIO_FRAC_BITS (RATIO_FRAC_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.cmd            (cmd),
		.sts            (sts),
		.ports_in_group (entry.ports_in_group),
		.out_ready      (slice.ready),
		.out_valid      (slice.valid),
		.elem_count     (slice.elem_count),
		.byte_size      (slice.byte_size),
		.byte_offset    (slice.byte_offset),
		.status         (slice.status),
		.last_slice     (slice.last_slice)
	);

endmodule

`default_nettype wire

>>> hdl/tlps_checker.sv
// Port-level checks of the split unit, bound to its top level.
// Depends on tlps_pkg for the status codes.
`default_nettype none

module tlps_checker import tlps_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              in_final,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [CNT_W-1:0]  out_elem,
	input wire logic [SIZE_W-1:0] out_size,
	input wire logic [SIZE_W-1:0] out_off,
	input wire logic [STAT_W-1:0] out_status,
	input wire logic              out_last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_elem) && $stable(out_off))
		else $error("slice request changed while stalled");

	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status != STAT_W'(ST_OK)) |-> out_last)
		else $error("error status without last_slice");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_status != STAT_W'(ST_OK)) |->
		(out_elem == '0) && (out_size == '0) && (out_off == '0))
		else $error("error status with nonzero payload");

	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !in_final && !out_valid |=> !out_valid)
		else $error("result appeared after a loading entry");

endmodule

bind two_level_port_group_split_unit tlps_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (entry.valid),
	.in_ready   (entry.ready),
	.in_final   (entry.final_channel),
	.out_valid  (slice.valid),
	.out_ready  (slice.ready),
	.out_elem   (slice.elem_count),
	.out_size   (slice.byte_size),
	.out_off    (slice.byte_offset),
	.out_status (slice.status),
	.out_last   (slice.last_slice)
);

`default_nettype wire
